// ----- rtl/pls_pkg.sv -----
// shared types and constants for the positional list store
`timescale 1ns / 1ps

package pls_pkg;

   localparam int CMD_BITS   = 2;
   localparam int POS_BITS   = 5;
   localparam int VALUE_BITS = 32;
   localparam int LEN_BITS   = 5;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_READ
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [POS_BITS-1:0]  idx;
   } cell_ctl_type;

endpackage

// ----- rtl/pls_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps

interface pls_req_if;
   import pls_pkg::*;

   logic                          valid;
   logic                          ready;
   logic [CMD_BITS-1:0]           cmd;
   logic [POS_BITS-1:0]           position;
   logic signed [VALUE_BITS-1:0]  new_value;

   modport source (output valid, output cmd, output position, output new_value, input ready);
   modport sink   (input valid, input cmd, input position, input new_value, output ready);
endinterface

interface pls_rsp_if;
   import pls_pkg::*;

   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic signed [VALUE_BITS-1:0]  read_value;
   logic [LEN_BITS-1:0]           length;

   modport source (output valid, output ok, output read_value, output length, input ready);
   modport sink   (input valid, input ok, input read_value, input length, output ready);
endinterface

// ----- rtl/pls_cell.sv -----
// one list cell: holds an element and trades it with its neighbors
`timescale 1ns / 1ps

module pls_cell #(
   parameter int INDEX       = 0,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  pls_pkg::cell_ctl_type   ctl,
   input  logic [VALUE_WIDTH-1:0]  new_value,
   input  logic [VALUE_WIDTH-1:0]  left_value,
   input  logic [VALUE_WIDTH-1:0]  right_value,
   output logic [VALUE_WIDTH-1:0]  value,
   output logic [VALUE_WIDTH-1:0]  read_data
);
   import pls_pkg::*;

   logic [VALUE_WIDTH-1:0] value_ff;
   logic [VALUE_WIDTH-1:0] value_in;
   logic                   hit;
   logic                   after;

   assign hit   = (int'(ctl.idx) == INDEX);
   assign after = (int'(ctl.idx) < INDEX);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (hit) begin
               value_in = new_value;
            end else if (after) begin
               value_in = left_value;
            end
         end
         CELL_DELETE: begin
            if (hit || after) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_data = (ctl.op == CELL_READ && hit) ? value_ff : '0;

endmodule

// ----- rtl/positional_list_store.sv -----
// Positional list store: an ordered list of signed values kept in a chain of cells.
//
// A request on req_chan carries cmd (insert, delete, read), a 1-based position and
// new_value. Insert puts new_value in front of the position (0 means the front),
// delete removes the element at the position (0 means the first), read returns it.
// Every request gives exactly one response on rsp_chan with ok, read_value (zero
// unless a read succeeded) and the list length after the command.
// The response is registered at the edge that takes the request. One request per
// cycle is sustained while responses are drained; each cell compares its index
// with the position and cells at or past it shift one place in that same cycle.
// A response waiting on a stalled receiver holds; a new request is taken only
// when the response register is empty or is being drained in that cycle.
// Reset empties the list; element contents are not cleared and only entries
// below the length are ever returned. Failed commands leave the list unchanged.
`timescale 1ns / 1ps

module positional_list_store #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req_chan,
   pls_rsp_if.source  rsp_chan
);
   import pls_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

   logic [CNT_W-1:0]             count_ff;
   logic [CNT_W-1:0]             count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         ok_ff;
   logic                         ok_in;
   logic [VALUE_BITS-1:0]        read_value_ff;
   logic [VALUE_BITS-1:0]        read_value_in;
   logic [LEN_BITS-1:0]          length_ff;
   logic [LEN_BITS-1:0]          length_in;

   logic                         transfer;
   logic [POS_BITS-1:0]          pos_eff;
   logic [CMP_W-1:0]             pos_ext;
   logic [CMP_W-1:0]             raw_pos_ext;
   logic [CMP_W-1:0]             cnt_ext;
   logic                         ins_ok;
   logic                         del_ok;
   logic                         rd_ok;
   cell_ctl_type                 ctl;
   logic [VALUE_WIDTH-1:0]       nv;
   logic [VALUE_WIDTH-1:0]       rd_sel;
   logic [VALUE_BITS-1:0]        rd_ext;

   logic [VALUE_WIDTH-1:0]       cell_value [CAPACITY];
   logic [VALUE_WIDTH-1:0]       cell_read  [CAPACITY];

   generate
      if (VALUE_WIDTH <= VALUE_BITS) begin : g_narrow
         assign nv = req_chan.new_value[VALUE_WIDTH-1:0];
      end else begin : g_wide_in
         assign nv = {{(VALUE_WIDTH-VALUE_BITS){req_chan.new_value[VALUE_BITS-1]}},
                      req_chan.new_value};
      end
      if (VALUE_WIDTH >= VALUE_BITS) begin : g_rd_trunc
         assign rd_ext = rd_sel[VALUE_BITS-1:0];
      end else begin : g_rd_sext
         assign rd_ext = {{(VALUE_BITS-VALUE_WIDTH){rd_sel[VALUE_WIDTH-1]}}, rd_sel};
      end
   endgenerate

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign transfer       = req_chan.valid && req_chan.ready;

   assign pos_eff     = (req_chan.position == '0) ? POS_BITS'(1) : req_chan.position;
   assign pos_ext     = CMP_W'(pos_eff);
   assign raw_pos_ext = CMP_W'(req_chan.position);
   assign cnt_ext     = CMP_W'(count_ff);
   assign ins_ok      = (pos_ext <= cnt_ext + CMP_W'(1)) && (count_ff < CNT_W'(CAPACITY));
   assign del_ok      = (pos_ext <= cnt_ext);
   assign rd_ok       = (req_chan.position != '0) && (raw_pos_ext <= cnt_ext);

   always_comb begin
      ctl.op   = CELL_HOLD;
      ctl.idx  = pos_eff - POS_BITS'(1);
      count_in = count_ff;
      ok_in    = 1'b0;
      if (transfer) begin
         case (req_chan.cmd)
            CMD_INSERT: begin
               if (ins_ok) begin
                  ctl.op   = CELL_INSERT;
                  count_in = count_ff + CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_DELETE: begin
               if (del_ok) begin
                  ctl.op   = CELL_DELETE;
                  count_in = count_ff - CNT_W'(1);
                  ok_in    = 1'b1;
               end
            end
            CMD_READ: begin
               ctl.op = CELL_READ;
               ok_in  = rd_ok;
            end
            default: begin
               ok_in = 1'b0;
            end
         endcase
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         pls_cell #(
            .INDEX       (gi),
            .VALUE_WIDTH (VALUE_WIDTH)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .new_value   (nv),
            .left_value  (cell_value[(gi == 0) ? 0 : gi - 1]),
            .right_value (cell_value[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .value       (cell_value[gi]),
            .read_data   (cell_read[gi])
         );
      end
   endgenerate

   always_comb begin
      rd_sel = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         rd_sel = rd_sel | cell_read[k];
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      read_value_in = read_value_ff;
      length_in     = length_ff;
      if (transfer) begin
         rsp_valid_in  = 1'b1;
         read_value_in = (ok_in && req_chan.cmd == CMD_READ) ? rd_ext : '0;
         length_in     = LEN_BITS'(CMP_W'(count_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         ok_ff <= ok_in;
      end
      read_value_ff <= read_value_in;
      length_ff     <= length_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.ok         = ok_ff;
   assign rsp_chan.read_value = read_value_ff;
   assign rsp_chan.length     = length_ff;

endmodule

// ----- rtl/pls_checker.sv -----
// port checker for the positional list store and its bind
`timescale 1ns / 1ps

module pls_checker #(
   parameter int CAPACITY = 16
) (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [pls_pkg::CMD_BITS-1:0]       req_cmd,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_ok,
   input logic [pls_pkg::VALUE_BITS-1:0]     rsp_read_value,
   input logic [pls_pkg::LEN_BITS-1:0]       rsp_length
);
   import pls_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok) &&
         $stable(rsp_read_value) && $stable(rsp_length))
      else $error("stalled response changed");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_value == '0)
      else $error("failed command returned data");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY >= 32) || (int'(rsp_length) <= CAPACITY))
      else $error("length beyond capacity");

   a_non_read_zero: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd != CMD_READ |=> rsp_read_value == '0)
      else $error("read data on non-read command");

endmodule

bind positional_list_store pls_checker #(
   .CAPACITY (CAPACITY)
) u_pls_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_cmd        (req_chan.cmd),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ok         (rsp_chan.ok),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_length     (rsp_chan.length)
);
